// ----- rtl/mtit_pkg.sv -----
// Shared types and codes for the multibit trie index table.
`timescale 1ns / 1ps
`default_nettype none

package mtit_pkg;

   localparam int STRIDE_BITS = 4;
   localparam int CSR_INDEX_BITS = 2;
   // three 4-bit strides sum to at most 45
   localparam int SUM_BITS = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL0_STRIDE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL1_STRIDE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL2_STRIDE = 2'd2;

   localparam logic [STRIDE_BITS-1:0] LEVEL0_STRIDE_RESET = 4'd4;
   localparam logic [STRIDE_BITS-1:0] LEVEL1_STRIDE_RESET = 4'd3;
   localparam logic [STRIDE_BITS-1:0] LEVEL2_STRIDE_RESET = 4'd3;

   localparam logic [2:0] OP_INSERT    = 3'd0;
   localparam logic [2:0] OP_DELETE    = 3'd1;
   localparam logic [2:0] OP_FIND      = 3'd2;
   localparam logic [2:0] OP_FIND_NEXT = 3'd3;
   localparam logic [2:0] OP_FIND_PREV = 3'd4;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TOO_LARGE = 3'd1;
   localparam logic [2:0] STATUS_OCCUPIED  = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_BAD_CFG   = 3'd4;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] key_index;
      logic [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        hit;
      logic [31:0] entry_out;
      logic [10:0] found_index;
      logic [10:0] entry_total;
      logic [10:0] level1_nodes;
      logic [10:0] level2_nodes;
   } rsp_type;

   // Stride setup as seen by the engine
   typedef struct packed {
      logic [STRIDE_BITS-1:0] s2;
      logic [SUM_BITS-1:0]    s1s2;
      logic [SUM_BITS-1:0]    slen;
      logic                   bad;
      logic                   clear;
   } cfg_type;

endpackage

`default_nettype wire

// ----- rtl/multibit_trie_index_table.sv -----
// Top level: stride registers and the table engine.
//
//  channel  prefix  direction  handshake
//  request  req_    in         req_valid / req_stall, payload mtit_pkg::req_type
//  result   rsp_    out        rsp_valid / rsp_stall, payload mtit_pkg::rsp_type
//  strides  csr_    in         csr_write, csr_index, csr_data
//
// Insert, delete and find go through the wait, evaluate and done states; error
// and unused-opcode results go from idle straight to done. A new request is
// taken only back in idle. Find next/prev read one bitmap word of up to 32
// keys per wait and evaluate step, then on a hit fetch the value in the
// fetch-wait and fetch states; the bitmap memory read sets this.
// After reset and after each stride write a clearing pass over every address
// runs with req_stall high. A stalled beat holds in the output register;
// a finished result waits in the engine while it holds in its last step.
`timescale 1ns / 1ps
`default_nettype none

module multibit_trie_index_table #(
   parameter int INDEX_BITS = 10,
   parameter int DATA_BITS  = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  mtit_pkg::req_type                      req,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output mtit_pkg::rsp_type                      rsp,
   input  logic                                   csr_write,
   input  logic [mtit_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mtit_pkg::STRIDE_BITS-1:0]       csr_data
);
   import mtit_pkg::*;

   logic [STRIDE_BITS-1:0] s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic                   hit_reg;
   logic [SUM_BITS-1:0]    slen;
   cfg_type                cfg;

   assign hit_reg = csr_write && (csr_index == CSR_LEVEL0_STRIDE ||
                                  csr_index == CSR_LEVEL1_STRIDE ||
                                  csr_index == CSR_LEVEL2_STRIDE);

   always_comb begin
      s0_in = s0_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      if (csr_write) begin
         if (csr_index == CSR_LEVEL0_STRIDE) s0_in = csr_data;
         if (csr_index == CSR_LEVEL1_STRIDE) s1_in = csr_data;
         if (csr_index == CSR_LEVEL2_STRIDE) s2_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= LEVEL0_STRIDE_RESET;
         s1_ff <= LEVEL1_STRIDE_RESET;
         s2_ff <= LEVEL2_STRIDE_RESET;
      end else begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign slen      = SUM_BITS'(s0_ff) + SUM_BITS'(s1_ff) + SUM_BITS'(s2_ff);
   assign cfg.s2    = s2_ff;
   assign cfg.s1s2  = SUM_BITS'(s1_ff) + SUM_BITS'(s2_ff);
   assign cfg.slen  = slen;
   assign cfg.bad   = int'(slen) > INDEX_BITS;
   assign cfg.clear = hit_reg && !reset;

   mtit_engine #(
      .INDEX_BITS(INDEX_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp      (rsp)
   );

endmodule

`default_nettype wire

// ----- rtl/mtit_engine.sv -----
// Table engine: bitmap, value and group-count memories plus the op sequencer.
`timescale 1ns / 1ps
`default_nettype none

module mtit_engine #(
   parameter int INDEX_BITS = 10,
   parameter int DATA_BITS  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  mtit_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  mtit_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtit_pkg::rsp_type rsp
);
   import mtit_pkg::*;

   localparam int IB    = INDEX_BITS;
   localparam int WB    = (IB >= 6) ? 5 : IB - 1;
   localparam int VW    = 1 << WB;
   localparam int AW    = IB - WB;
   localparam int CW    = IB + 1;
   localparam int DEPTH = 1 << IB;
   localparam int WORDS = 1 << AW;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WAIT  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_FWAIT = 3'd4;
   localparam logic [2:0] S_FGET  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   function automatic logic [WB-1:0] low_set(input logic [VW-1:0] w);
      logic [WB-1:0] p;
      p = '0;
      for (int i = VW - 1; i >= 0; i--) begin
         if (w[i]) p = WB'(i);
      end
      return p;
   endfunction

   function automatic logic [WB-1:0] high_set(input logic [VW-1:0] w);
      logic [WB-1:0] p;
      p = '0;
      for (int i = 0; i < VW; i++) begin
         if (w[i]) p = WB'(i);
      end
      return p;
   endfunction

   function automatic logic [10:0] fit11(input logic [CW-1:0] x);
      logic [31:0] w;
      w = 32'(x);
      return w[10:0];
   endfunction

   function automatic logic [31:0] fit32(input logic [DATA_BITS-1:0] x);
      logic [63:0] w;
      w = 64'(x);
      return w[31:0];
   endfunction

   // memories
   logic [VW-1:0]        vmem [WORDS];
   logic [DATA_BITS-1:0] dmem [DEPTH];
   logic [CW-1:0]        lmem [DEPTH];
   logic [CW-1:0]        mmem [DEPTH];

   logic [VW-1:0]        vrd_ff;
   logic [DATA_BITS-1:0] drd_ff;
   logic [CW-1:0]        lrd_ff, mrd_ff;

   logic                 v_we, d_we, l_we, m_we;
   logic [AW-1:0]        v_wa;
   logic [VW-1:0]        v_wd;
   logic [IB-1:0]        l_wa, m_wa;
   logic [CW-1:0]        l_wd, m_wd;

   logic [2:0]           state_ff, state_in;
   logic [IB-1:0]        clr_ff, clr_in;
   logic [2:0]           op_ff, op_in;
   logic [IB-1:0]        key_ff, key_in;
   logic [DATA_BITS-1:0] val_ff, val_in;
   logic [AW-1:0]        vaddr_ff, vaddr_in;
   logic [IB-1:0]        daddr_ff, daddr_in;
   logic [IB-1:0]        laddr_ff, laddr_in;
   logic [IB-1:0]        maddr_ff, maddr_in;
   logic                 first_ff, first_in;
   logic [CW-1:0]        limit_ff, limit_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CW-1:0]        lvl1_ff, lvl1_in;
   logic [CW-1:0]        lvl2_ff, lvl2_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [WB-1:0]        bpos;
   logic                 vbit;
   logic [VW-1:0]        up_mask, dn_mask, masked;
   logic [WB-1:0]        lo_pos, hi_pos;
   logic                 too_large;
   logic [IB-1:0]        req_key;
   logic [63:0]          req_val_wide;

   always_ff @(posedge clock) begin
      if (v_we) vmem[v_wa] <= v_wd;
      vrd_ff <= vmem[vaddr_ff];
   end

   always_ff @(posedge clock) begin
      if (d_we) dmem[daddr_ff] <= val_ff;
      drd_ff <= dmem[daddr_ff];
   end

   always_ff @(posedge clock) begin
      if (l_we) lmem[l_wa] <= l_wd;
      lrd_ff <= lmem[laddr_ff];
   end

   always_ff @(posedge clock) begin
      if (m_we) mmem[m_wa] <= m_wd;
      mrd_ff <= mmem[maddr_ff];
   end

   assign bpos    = key_ff[WB-1:0];
   assign vbit    = vrd_ff[bpos];
   assign up_mask = {VW{1'b1}} << bpos;
   assign dn_mask = {VW{1'b1}} >> (WB'(VW - 1) - bpos);
   assign masked  = vrd_ff & (first_ff ? ((op_ff == OP_FIND_NEXT) ? up_mask : dn_mask)
                                       : {VW{1'b1}});
   assign lo_pos  = low_set(masked);
   assign hi_pos  = high_set(masked);

   assign too_large    = (req.key_index >> cfg.slen) != 32'd0;
   assign req_key      = req.key_index[IB-1:0];
   assign req_val_wide = 64'(req.entry_value);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      vaddr_in     = vaddr_ff;
      daddr_in     = daddr_ff;
      laddr_in     = laddr_ff;
      maddr_in     = maddr_ff;
      first_in     = first_ff;
      limit_in     = limit_ff;
      total_in     = total_ff;
      lvl1_in      = lvl1_ff;
      lvl2_in      = lvl2_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      v_we = 1'b0;  v_wa = vaddr_ff;  v_wd = vrd_ff;
      d_we = 1'b0;
      l_we = 1'b0;  l_wa = laddr_ff;  l_wd = lrd_ff;
      m_we = 1'b0;  m_wa = maddr_ff;  m_wd = mrd_ff;

      unique case (state_ff)
         S_CLEAR: begin
            v_we = 1'b1;  v_wa = clr_ff[AW-1:0];  v_wd = '0;
            l_we = 1'b1;  l_wa = clr_ff;          l_wd = '0;
            m_we = 1'b1;  m_wa = clr_ff;          m_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == {IB{1'b1}}) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req.opcode;
               key_in   = req_key;
               val_in   = req_val_wide[DATA_BITS-1:0];
               vaddr_in = req_key[IB-1:WB];
               daddr_in = req_key;
               laddr_in = req_key >> cfg.s2;
               maddr_in = req_key >> cfg.s1s2;
               limit_in = CW'(1) << cfg.slen;
               first_in = 1'b1;
               res_in   = '0;
               if (cfg.bad) begin
                  res_in.status = STATUS_BAD_CFG;
                  state_in      = S_DONE;
               end else if (req.opcode > OP_FIND_PREV) begin
                  state_in = S_DONE;
               end else if (too_large) begin
                  res_in.status = STATUS_TOO_LARGE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_WAIT;
               end
            end
         end
         S_WAIT: state_in = S_EVAL;
         S_EVAL: begin
            state_in = S_DONE;
            first_in = 1'b0;
            unique case (op_ff)
               OP_INSERT: begin
                  if (vbit) begin
                     res_in.status = STATUS_OCCUPIED;
                  end else begin
                     v_we = 1'b1;  v_wd = vrd_ff | (VW'(1) << bpos);
                     d_we = 1'b1;
                     l_we = 1'b1;  l_wd = lrd_ff + 1'b1;
                     total_in = total_ff + 1'b1;
                     // first entry of a leaf group opens it in its level-one slot
                     if (lrd_ff == '0) begin
                        m_we    = 1'b1;
                        m_wd    = mrd_ff + 1'b1;
                        lvl2_in = lvl2_ff + 1'b1;
                        if (mrd_ff == '0) lvl1_in = lvl1_ff + 1'b1;
                     end
                  end
               end
               OP_DELETE: begin
                  if (!vbit) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     res_in.hit       = 1'b1;
                     res_in.entry_out = fit32(drd_ff);
                     v_we = 1'b1;  v_wd = vrd_ff & ~(VW'(1) << bpos);
                     l_we = 1'b1;  l_wd = lrd_ff - 1'b1;
                     total_in = total_ff - 1'b1;
                     if (lrd_ff == CW'(1)) begin
                        m_we    = 1'b1;
                        m_wd    = mrd_ff - 1'b1;
                        lvl2_in = lvl2_ff - 1'b1;
                        if (mrd_ff == CW'(1)) lvl1_in = lvl1_ff - 1'b1;
                     end
                  end
               end
               OP_FIND: begin
                  if (!vbit) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     res_in.hit       = 1'b1;
                     res_in.entry_out = fit32(drd_ff);
                  end
               end
               OP_FIND_NEXT: begin
                  if (masked != '0) begin
                     daddr_in = {vaddr_ff, lo_pos};
                     state_in = S_FWAIT;
                  end else if (vaddr_ff == {AW{1'b1}}) begin
                     res_in.status      = STATUS_NOT_FOUND;
                     res_in.found_index = fit11(limit_ff);
                  end else begin
                     vaddr_in = vaddr_ff + 1'b1;
                     state_in = S_WAIT;
                  end
               end
               OP_FIND_PREV: begin
                  if (masked != '0) begin
                     daddr_in = {vaddr_ff, hi_pos};
                     state_in = S_FWAIT;
                  end else if (vaddr_ff == '0) begin
                     res_in.status = STATUS_NOT_FOUND;
                  end else begin
                     vaddr_in = vaddr_ff - 1'b1;
                     state_in = S_WAIT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_FWAIT: state_in = S_FGET;
         S_FGET: begin
            res_in.status      = STATUS_OK;
            res_in.hit         = 1'b1;
            res_in.entry_out   = fit32(drd_ff);
            res_in.found_index = fit11(CW'(daddr_ff));
            state_in           = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in              = res_ff;
               rsp_in.entry_total  = fit11(total_ff);
               rsp_in.level1_nodes = fit11(lvl1_ff);
               rsp_in.level2_nodes = fit11(lvl2_ff);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // a stride write drops the whole table
      if (cfg.clear) begin
         state_in = S_CLEAR;
         clr_in   = '0;
         total_in = '0;
         lvl1_in  = '0;
         lvl2_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         lvl1_ff      <= '0;
         lvl2_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         lvl1_ff      <= lvl1_in;
         lvl2_ff      <= lvl2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      key_ff   <= key_in;
      val_ff   <= val_in;
      vaddr_ff <= vaddr_in;
      daddr_ff <= daddr_in;
      laddr_ff <= laddr_in;
      maddr_ff <= maddr_in;
      first_ff <= first_in;
      limit_ff <= limit_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/mtit_checker.sv -----
// Port-level checks for the multibit trie index table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mtit_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mtit_pkg::rsp_type rsp
);
   import mtit_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result beat changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // one item at a time: the request side closes after each accepted beat
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted back to back");

   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.hit |-> rsp.status == STATUS_OK)
      else $error("hit with error status");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == STATUS_TOO_LARGE || rsp.status == STATUS_OCCUPIED ||
                    rsp.status == STATUS_BAD_CFG)
      |-> !rsp.hit && rsp.entry_out == 32'd0 && rsp.found_index == 11'd0)
      else $error("error result carries data");

endmodule

bind multibit_trie_index_table mtit_checker u_mtit_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp      (rsp)
);

`default_nettype wire

// ----- tb/multibit_trie_index_table_tb.sv -----
// Self-checking testbench for the multibit trie index table: directed table plus random traffic.
`timescale 1ns / 1ps
`default_nettype none

module multibit_trie_index_table_tb;
   import mtit_pkg::*;

   localparam int TABLE_KEYS = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_LEVEL0_STRIDE;
   logic [STRIDE_BITS-1:0] csr_data = '0;

   multibit_trie_index_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // shadow of the table
   logic [31:0] tbl_value [TABLE_KEYS];
   bit          tbl_used  [TABLE_KEYS];
   int          leaf_cnt  [TABLE_KEYS];
   int          mid_cnt   [TABLE_KEYS];
   int          n_entries, n_level1, n_level2;
   int          stride [3];

   rsp_type pending_rsp [$];
   int      err_count = 0;
   int      send_idle = 0;
   int      recv_idle = 0;

   typedef struct {
      logic [2:0]  op;
      logic [31:0] key;
      logic [31:0] val;
      bit          typed;
      rsp_type     want;
   } plan_row;

   function automatic void clear_table();
      for (int i = 0; i < TABLE_KEYS; i++) begin
         tbl_used[i] = 0;
         leaf_cnt[i] = 0;
         mid_cnt[i] = 0;
      end
      n_entries = 0;
      n_level1 = 0;
      n_level2 = 0;
   endfunction

   function automatic rsp_type lookup_and_update(req_type r);
      rsp_type o;
      int slen, limit, k, g1, g2;
      o = '0;
      slen = stride[0] + stride[1] + stride[2];
      limit = 1 << slen;
      k = r.key_index[9:0];
      g2 = k >> stride[2];
      g1 = k >> (stride[1] + stride[2]);
      if (slen > 10) begin
         o.status = STATUS_BAD_CFG;
      end else if (r.opcode <= OP_FIND_PREV && longint'(r.key_index) >= longint'(limit)) begin
         o.status = STATUS_TOO_LARGE;
      end else begin
         case (r.opcode)
            OP_INSERT: begin
               if (tbl_used[k]) begin
                  o.status = STATUS_OCCUPIED;
               end else begin
                  if (leaf_cnt[g2] == 0) begin
                     if (mid_cnt[g1] == 0) n_level1++;
                     mid_cnt[g1]++;
                     n_level2++;
                  end
                  leaf_cnt[g2]++;
                  tbl_used[k] = 1;
                  tbl_value[k] = r.entry_value;
                  n_entries++;
               end
            end
            OP_DELETE: begin
               if (!tbl_used[k]) begin
                  o.status = STATUS_NOT_FOUND;
               end else begin
                  o.hit = 1'b1;
                  o.entry_out = tbl_value[k];
                  tbl_used[k] = 0;
                  n_entries--;
                  leaf_cnt[g2]--;
                  if (leaf_cnt[g2] == 0) begin
                     n_level2--;
                     mid_cnt[g1]--;
                     if (mid_cnt[g1] == 0) n_level1--;
                  end
               end
            end
            OP_FIND: begin
               if (!tbl_used[k]) begin
                  o.status = STATUS_NOT_FOUND;
               end else begin
                  o.hit = 1'b1;
                  o.entry_out = tbl_value[k];
               end
            end
            OP_FIND_NEXT: begin
               o.status = STATUS_NOT_FOUND;
               o.found_index = 11'(limit);
               for (int i = k; i < limit; i++) begin
                  if (tbl_used[i]) begin
                     o.status = STATUS_OK;
                     o.hit = 1'b1;
                     o.entry_out = tbl_value[i];
                     o.found_index = 11'(i);
                     break;
                  end
               end
            end
            OP_FIND_PREV: begin
               o.status = STATUS_NOT_FOUND;
               for (int i = k; i >= 0; i--) begin
                  if (tbl_used[i]) begin
                     o.status = STATUS_OK;
                     o.hit = 1'b1;
                     o.entry_out = tbl_value[i];
                     o.found_index = 11'(i);
                     break;
                  end
               end
            end
            default: ;  // unused opcodes leave the table alone
         endcase
      end
      o.entry_total = 11'(n_entries);
      o.level1_nodes = 11'(n_level1);
      o.level2_nodes = 11'(n_level2);
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // result side: stall pattern and checking
   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < recv_idle);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected beat", longint'(rsp.status), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
            if (rsp.hit !== want.hit) report_mismatch("hit", rsp.hit, want.hit);
            if (rsp.entry_out !== want.entry_out)
               report_mismatch("entry_out", rsp.entry_out, want.entry_out);
            if (rsp.found_index !== want.found_index)
               report_mismatch("found_index", rsp.found_index, want.found_index);
            if (rsp.entry_total !== want.entry_total)
               report_mismatch("entry_total", rsp.entry_total, want.entry_total);
            if (rsp.level1_nodes !== want.level1_nodes)
               report_mismatch("level1_nodes", rsp.level1_nodes, want.level1_nodes);
            if (rsp.level2_nodes !== want.level2_nodes)
               report_mismatch("level2_nodes", rsp.level2_nodes, want.level2_nodes);
         end
      end
   end

   // called at a falling edge; returns at a falling edge after the beat is taken
   task automatic send_beat(req_type r, bit typed, rsp_type want);
      rsp_type pred;
      if ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle) @(negedge clock);
      end
      req <= r;
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pred = lookup_and_update(r);
      pending_rsp.push_back(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic set_strides(int s0, int s1, int s2);
      int vals [3];
      vals = '{s0, s1, s2};
      drain();
      for (int i = 0; i < 3; i++) begin
         csr_index <= CSR_INDEX_BITS'(i);
         csr_data <= STRIDE_BITS'(vals[i]);
         csr_write <= 1'b1;
         @(negedge clock);
         stride[i] = vals[i];
         clear_table();
      end
      csr_write <= 1'b0;
   endtask

   function automatic req_type random_item();
      req_type r;
      int slen, limit, pick;
      slen = stride[0] + stride[1] + stride[2];
      limit = (slen > 10) ? TABLE_KEYS : (1 << slen);
      pick = $urandom_range(0, 99);
      if (pick < 35) r.opcode = OP_INSERT;
      else if (pick < 55) r.opcode = OP_DELETE;
      else if (pick < 70) r.opcode = OP_FIND;
      else if (pick < 82) r.opcode = OP_FIND_NEXT;
      else if (pick < 94) r.opcode = OP_FIND_PREV;
      else r.opcode = 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      if (pick < 86) r.key_index = $urandom_range(0, limit - 1);
      else if (pick < 92) r.key_index = limit + $urandom_range(0, 3);
      else if (pick < 97) r.key_index = $urandom;
      else r.key_index = 32'hffff_ffff;
      r.entry_value = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom;
      return r;
   endfunction

   plan_row plan [19];
   int cfg_list [10][4] = '{
      '{4, 3, 3, 180}, '{10, 0, 0, 180}, '{0, 0, 0, 40}, '{2, 2, 2, 180}, '{0, 0, 10, 180},
      '{15, 15, 15, 30}, '{3, 4, 3, 180}, '{5, 5, 1, 30}, '{1, 1, 1, 120}, '{4, 3, 3, 180}
   };

   initial begin
      int sent;
      rsp_type none;
      none = '0;
      plan = '{
         '{OP_FIND,      32'd0,    32'h0, 1, '{STATUS_NOT_FOUND, 0, 0, 0, 0, 0, 0}},
         '{OP_FIND_NEXT, 32'd0,    32'h0, 1, '{STATUS_NOT_FOUND, 0, 0, 1024, 0, 0, 0}},
         '{OP_FIND_PREV, 32'd1023, 32'h0, 1, '{STATUS_NOT_FOUND, 0, 0, 0, 0, 0, 0}},
         '{OP_INSERT,    32'd0,    32'h0, 1, '{STATUS_OK, 0, 0, 0, 1, 1, 1}},
         '{OP_INSERT,    32'd0,    32'hffff_ffff, 1, '{STATUS_OCCUPIED, 0, 0, 0, 1, 1, 1}},
         '{OP_INSERT,    32'd1023, 32'hffff_ffff, 0, none},
         '{OP_INSERT,    32'd1022, 32'ha5a5_a5a5, 0, none},
         '{OP_FIND,      32'd0,    32'h0, 0, none},
         '{OP_FIND_NEXT, 32'd1,    32'h0, 0, none},
         '{OP_FIND_PREV, 32'd1021, 32'h0, 0, none},
         '{OP_INSERT,    32'd1024, 32'h1234_5678, 1, '{STATUS_TOO_LARGE, 0, 0, 0, 3, 2, 2}},
         '{OP_FIND_NEXT, 32'hffff_ffff, 32'h0, 1, '{STATUS_TOO_LARGE, 0, 0, 0, 3, 2, 2}},
         '{3'd5,         32'd0,    32'h5555_5555, 1, '{STATUS_OK, 0, 0, 0, 3, 2, 2}},
         '{3'd7,         32'hffff_ffff, 32'hffff_ffff, 1, '{STATUS_OK, 0, 0, 0, 3, 2, 2}},
         '{OP_DELETE,    32'd1023, 32'h0, 0, none},
         '{OP_DELETE,    32'd1023, 32'h0, 1, '{STATUS_NOT_FOUND, 0, 0, 0, 2, 2, 2}},
         '{OP_DELETE,    32'd1022, 32'h0, 0, none},
         '{OP_DELETE,    32'd0,    32'h0, 0, none},
         '{OP_FIND_NEXT, 32'd0,    32'h0, 1, '{STATUS_NOT_FOUND, 0, 0, 1024, 0, 0, 0}}
      };
      stride = '{int'(LEVEL0_STRIDE_RESET), int'(LEVEL1_STRIDE_RESET),
                 int'(LEVEL2_STRIDE_RESET)};
      clear_table();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle = 23;
      recv_idle = 83;
      foreach (plan[i])
         send_beat('{plan[i].op, plan[i].key, plan[i].val}, plan[i].typed, plan[i].want);

      sent = 0;
      foreach (cfg_list[c]) begin
         set_strides(cfg_list[c][0], cfg_list[c][1], cfg_list[c][2]);
         for (int n = 0; n < cfg_list[c][3]; n++) begin
            if (sent == 450) begin
               send_idle = 83;
               recv_idle = 23;
            end else if (sent == 900) begin
               send_idle = 0;
               recv_idle = 0;
            end
            // hold off until the table has answered everything
            if (n == 60) drain();
            send_beat(random_item(), 0, none);
            sent++;
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire
